/* hdl/cat_pkg.sv */
package cat_pkg;

    typedef struct packed {
        logic [15:0] bus_addr;
        logic        is_write;
    } cat_in_t;

    typedef struct packed {
        logic [27:0] physical_address;
        logic [3:0]  mechanism;
    } cat_out_t;

    typedef struct packed {
        logic [15:0] map_low_window;
        logic [15:0] map_high_window;
        logic [7:0]  low_megabyte;
        logic [7:0]  high_megabyte;
        logic [7:0]  port_direction;
        logic [7:0]  port_value;
        logic [7:0]  rom_select;
    } cat_cfg_t;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_MAP_LOW_WINDOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_HIGH_WINDOW = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_MEGABYTE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_MEGABYTE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PORT_DIRECTION  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PORT_VALUE      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROM_SELECT      = 3'd6;

    localparam logic [3:0] MECH_RAM      = 4'd0;
    localparam logic [3:0] MECH_MAP_LOW  = 4'd1;
    localparam logic [3:0] MECH_MAP_HIGH = 4'd2;
    localparam logic [3:0] MECH_CART_IO  = 4'd3;
    localparam logic [3:0] MECH_PORT     = 4'd4;
    localparam logic [3:0] MECH_ROM8     = 4'd5;
    localparam logic [3:0] MECH_ROMA     = 4'd6;
    localparam logic [3:0] MECH_ROMC     = 4'd7;
    localparam logic [3:0] MECH_ROME     = 4'd8;

    localparam logic [27:0] ROM_SHADOW_BASE   = 28'h0020000;
    localparam logic [27:0] IO_PAGE_BASE      = 28'hFFD3000;
    localparam logic [27:0] CART_IO_BASE      = 28'h7FFD000;
    localparam logic [27:0] CHAR_ROM_BASE     = 28'h002D000;
    localparam logic [27:0] RAM_UNDER_IO_BASE = 28'h000D000;
    localparam logic [15:0] CART_IO_FIRST     = 16'hDE00;
    localparam logic [3:0]  IO_NIBBLE         = 4'hD;

    // Bit of the ROM-banking register that covers a 4KB window from $8000 upwards.
    function automatic logic [7:0] window_bit(input logic [2:0] w);
        logic [7:0] r;
        begin
            case (w)
                3'd0, 3'd1: r = 8'h08;
                3'd2, 3'd3: r = 8'h10;
                3'd4:       r = 8'h20;
                3'd6, 3'd7: r = 8'h80;
                default:    r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [3:0] window_mech(input logic [2:0] w);
        logic [3:0] r;
        begin
            case (w)
                3'd0, 3'd1: r = MECH_ROM8;
                3'd2, 3'd3: r = MECH_ROMA;
                3'd4:       r = MECH_ROMC;
                3'd6, 3'd7: r = MECH_ROME;
                default:    r = MECH_RAM;
            endcase
            return r;
        end
    endfunction

endpackage

/* hdl/cat_cfg_regs.sv */
module cat_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [cat_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cat_pkg::CFG_DATA_W-1:0]    cfg_data,
    output cat_pkg::cat_cfg_t                 cfg
);

    cat_pkg::cat_cfg_t cfg_reg;
    cat_pkg::cat_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                cat_pkg::REG_MAP_LOW_WINDOW:  cfg_next.map_low_window  = cfg_data;
                cat_pkg::REG_MAP_HIGH_WINDOW: cfg_next.map_high_window = cfg_data;
                cat_pkg::REG_LOW_MEGABYTE:    cfg_next.low_megabyte    = cfg_data[7:0];
                cat_pkg::REG_HIGH_MEGABYTE:   cfg_next.high_megabyte   = cfg_data[7:0];
                cat_pkg::REG_PORT_DIRECTION:  cfg_next.port_direction  = cfg_data[7:0];
                cat_pkg::REG_PORT_VALUE:      cfg_next.port_value      = cfg_data[7:0];
                cat_pkg::REG_ROM_SELECT:      cfg_next.rom_select      = cfg_data[7:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/cat_xlate.sv */
module cat_xlate (
    input  cat_pkg::cat_cfg_t cfg,
    input  cat_pkg::cat_in_t  item,
    output cat_pkg::cat_out_t result
);

    logic [15:0] addr;
    logic        wr;
    logic        low_half;
    logic [15:0] map;
    logic [3:0]  map_enables;
    logic        map_hit;
    logic [7:0]  mb;
    logic [19:0] map_sum;
    logic [3:0]  nib;
    logic [2:0]  lines;
    logic [27:0] low12;
    logic [27:0] rom_addr;
    logic [27:0] phys;
    logic [3:0]  mech;

    assign addr        = item.bus_addr;
    assign wr          = item.is_write;
    assign low_half    = ~addr[15];
    assign map         = low_half ? cfg.map_low_window : cfg.map_high_window;
    assign map_enables = map[15:12];
    assign map_hit     = map_enables[addr[14:13]];
    assign mb          = low_half ? cfg.low_megabyte : cfg.high_megabyte;
    assign map_sum     = {4'd0, addr} + {map[11:0], 8'd0};
    assign nib         = addr[15:12];
    assign lines       = cfg.port_value[2:0] | ~cfg.port_direction[2:0];
    assign low12       = {16'd0, addr[11:0]};
    assign rom_addr    = cat_pkg::ROM_SHADOW_BASE + {12'd0, addr};

    always_comb
    begin
        phys = {12'd0, addr};
        mech = cat_pkg::MECH_RAM;
        if (map_hit)
        begin
            phys = {mb, map_sum};
            mech = low_half ? cat_pkg::MECH_MAP_LOW : cat_pkg::MECH_MAP_HIGH;
        end
        else
        begin
            if (nib == cat_pkg::IO_NIBBLE)
            begin
                if (lines >= 3'd5)
                begin
                    if (addr >= cat_pkg::CART_IO_FIRST && !cfg.rom_select[0])
                    begin
                        phys = cat_pkg::CART_IO_BASE | low12;
                        mech = cat_pkg::MECH_CART_IO;
                    end
                    else
                    begin
                        phys = cat_pkg::IO_PAGE_BASE | low12;
                        mech = cat_pkg::MECH_PORT;
                    end
                end
                else if (lines != 3'd0 && lines != 3'd4)
                begin
                    phys = (wr ? cat_pkg::RAM_UNDER_IO_BASE : cat_pkg::CHAR_ROM_BASE) | low12;
                    mech = cat_pkg::MECH_PORT;
                end
                else
                begin
                    phys = cat_pkg::RAM_UNDER_IO_BASE | low12;
                end
            end
            if (!wr)
            begin
                if ((nib >= 4'hE && lines[1]) ||
                    ((nib == 4'hA || nib == 4'hB) && lines[1:0] == 2'b11))
                begin
                    phys = rom_addr;
                    mech = cat_pkg::MECH_PORT;
                end
                if (nib[3] && (cfg.rom_select & cat_pkg::window_bit(nib[2:0])) != 8'd0)
                begin
                    phys = rom_addr;
                    mech = cat_pkg::window_mech(nib[2:0]);
                end
            end
        end
    end

    assign result.physical_address = phys;
    assign result.mechanism        = mech;

endmodule

/* hdl/cpu_address_translator.sv */
// Translates a 16-bit processor address and a read/write flag into a 28-bit physical
// address together with a code naming the mechanism that decided it. The block accepts
// one item per clock cycle while the output is not stalled. An item taken at the input
// sits in an input register, and the translation logic loads its result into a result
// register, from which it is offered at the output until taken. Either register accepts
// a new item whenever it is empty or its contents are being taken in the same cycle.
// Configuration writes take effect on the following cycle and should only be made while
// no item is in flight.
module cpu_address_translator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  cat_pkg::cat_in_t                  in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cat_pkg::cat_out_t                 out_item,
    input  logic                              cfg_write,
    input  logic [cat_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cat_pkg::CFG_DATA_W-1:0]    cfg_data
);

    cat_pkg::cat_cfg_t cfg;
    cat_pkg::cat_out_t xlate_result;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    cat_pkg::cat_in_t  s1_item_reg;
    logic              s1_ready;
    logic              out_valid_reg;
    logic              out_valid_next;
    cat_pkg::cat_out_t out_item_reg;

    cat_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cat_xlate u_xlate (
        .cfg    (cfg),
        .item   (s1_item_reg),
        .result (xlate_result)
    );

    assign s1_ready       = !out_valid_reg || out_ready;
    assign in_ready       = !s1_valid_reg || s1_ready;
    assign s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
    assign out_valid_next = s1_ready ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_valid_reg && s1_ready)
        begin
            out_item_reg <= xlate_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // An item taken at the input is always held in the input register on the next cycle.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted item did not reach the input register");

    // An item held back by a stalled result register must not change.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_ready) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("input register changed while stalled");

    // A write never reaches a ROM window.
    a_write_no_rom: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_item_reg.is_write && !(xlate_result.mechanism ==
            cat_pkg::MECH_MAP_LOW || xlate_result.mechanism == cat_pkg::MECH_MAP_HIGH)) |->
        !(xlate_result.mechanism == cat_pkg::MECH_ROM8 ||
          xlate_result.mechanism == cat_pkg::MECH_ROMA ||
          xlate_result.mechanism == cat_pkg::MECH_ROMC ||
          xlate_result.mechanism == cat_pkg::MECH_ROME))
        else $error("write item routed to ROM");

    // The upper-half MAP mechanism only serves addresses in the upper half.
    a_map_half: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && xlate_result.mechanism == cat_pkg::MECH_MAP_HIGH) |->
        s1_item_reg.bus_addr[15])
        else $error("upper MAP mechanism used for a lower-half address");

    // A result taken from the output register is replaced in the same edge if one waits.
    a_out_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && s1_valid_reg) |=> out_valid_reg)
        else $error("result register not refilled");

endmodule
